>>> sv/assert_macros.svh
// Assertion macros shared by the memory map RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define MMRR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the next cycle.
`define MMRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/mmrr_pkg.sv
// ----------------------------------------------------------------------------
// Memory map range retype package
// Shared widths, action and status codes, table entry and control structs.
// ----------------------------------------------------------------------------
package mmrr_pkg;

  localparam int ADDR_W  = 64;
  localparam int TYPE_W  = 2;
  localparam int IDX_W   = 5;
  localparam int COUNT_W = 6;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_RETYPE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_IDX  = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] head;
    logic [ADDR_W-1:0] tail;
    logic [TYPE_W-1:0] ty;
  } ent_t;

  typedef struct packed {
    logic load;
    logic pass_init;
    logic p1_run;
    logic p1_close;
    logic p2_run;
    logic span_wr;
    logic a_rd;
    logic a_ev;
    logic r_rd;
    logic r_ev;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       bad;
    logic       pass_end;
    logic       out_free;
  } sts_t;

endpackage

>>> sv/mmrr_if.sv
// ----------------------------------------------------------------------------
// Memory map channel interfaces
// Request channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface mmrr_in_if
  import mmrr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [ADDR_W-1:0] range_head;
  logic [ADDR_W-1:0] range_tail;
  logic [TYPE_W-1:0] region_type;
  logic [IDX_W-1:0]  entry_index;

  modport source (output valid, action, range_head, range_tail, region_type,
                  entry_index, input ready);
  modport sink (input valid, action, range_head, range_tail, region_type,
                entry_index, output ready);
endinterface

interface mmrr_out_if
  import mmrr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  entry_head;
  logic [ADDR_W-1:0]  entry_tail;
  logic [TYPE_W-1:0]  entry_type;
  logic [COUNT_W-1:0] region_count;
  logic [1:0]         status;

  modport source (output valid, entry_head, entry_tail, entry_type, region_count,
                  status, input ready);
  modport sink (input valid, entry_head, entry_tail, entry_type, region_count,
                status, output ready);
endinterface

>>> sv/mmrr_ctrl.sv
// ----------------------------------------------------------------------------
// Memory map controller
// Sequences append, read and the two-pass retype walk over the table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmrr_ctrl
  import mmrr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_ARD  = 4'd2;
  localparam logic [3:0] S_AEV  = 4'd3;
  localparam logic [3:0] S_RRD  = 4'd4;
  localparam logic [3:0] S_REV  = 4'd5;
  localparam logic [3:0] S_P1   = 4'd6;
  localparam logic [3:0] S_P2   = 4'd7;
  localparam logic [3:0] S_SPAN = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.act)
          ACT_APPEND: state_nxt = S_ARD;
          ACT_RETYPE: begin
            if (sts.bad) begin
              state_nxt = S_DONE;
            end else begin
              cmd.pass_init = 1'b1;
              state_nxt     = S_P1;
            end
          end
          ACT_READ: state_nxt = S_RRD;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_ARD: begin
        cmd.a_rd  = 1'b1;
        state_nxt = S_AEV;
      end
      S_AEV: begin
        cmd.a_ev  = 1'b1;
        state_nxt = S_DONE;
      end
      S_RRD: begin
        cmd.r_rd  = 1'b1;
        state_nxt = S_REV;
      end
      S_REV: begin
        cmd.r_ev  = 1'b1;
        state_nxt = S_DONE;
      end
      S_P1: begin
        cmd.p1_run = 1'b1;
        if (sts.pass_end) begin
          cmd.p1_close = 1'b1;
          state_nxt    = S_P2;
        end
      end
      S_P2: begin
        cmd.p2_run = 1'b1;
        if (sts.pass_end) begin
          state_nxt = S_SPAN;
        end
      end
      S_SPAN: begin
        cmd.span_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MMRR_ASSERT_NEXT(a_accept_disp, in_acc, state_r == S_DISP)
  `MMRR_ASSERT_NEXT(a_fin_idle, cmd.fin, state_r == S_IDLE)
  `MMRR_ASSERT_IMPL(a_span_after_p2, state_r == S_SPAN, $past(state_r) == S_P2)

endmodule

>>> sv/mmrr_dpath.sv
// ----------------------------------------------------------------------------
// Memory map datapath
// Two-bank region table, retype walk pointers and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmrr_dpath
  import mmrr_pkg::*;
#(
  parameter int MAX_REGIONS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_action,
  input  logic [ADDR_W-1:0]  in_head,
  input  logic [ADDR_W-1:0]  in_tail,
  input  logic [TYPE_W-1:0]  in_type,
  input  logic [IDX_W-1:0]   in_index,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [ADDR_W-1:0]  out_head,
  output logic [ADDR_W-1:0]  out_tail,
  output logic [TYPE_W-1:0]  out_type,
  output logic [COUNT_W-1:0] out_count,
  output logic [1:0]         out_status
);

  // A retype result can hold two more regions than the table limit before
  // the overflow check rejects it.
  localparam int DEPTH = MAX_REGIONS + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = (CW > IDX_W) ? CW : IDX_W;

  ent_t mem [2][DEPTH];
  ent_t rd_r;

  logic [1:0]        act_r;
  logic [ADDR_W-1:0] h_r, t_r;
  logic [TYPE_W-1:0] ty_r;
  logic [IDX_W-1:0]  idx_r;

  logic [CW-1:0] used_r, used_nxt;
  logic          bank_r, bank_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          pv_r, pv_nxt;
  logic [CW-1:0] wptr_r, wptr_nxt;
  logic [CW-1:0] spa_r, spa_nxt;
  logic [ADDR_W-1:0] sph_r, sph_nxt, spt_r, spt_nxt;
  ent_t          last_r, last_nxt;
  logic          lv_r, lv_nxt;
  logic          first_r, first_nxt;

  logic               ov_r, ov_nxt;
  logic [ADDR_W-1:0]  eh_r, eh_nxt, et_r, et_nxt;
  logic [TYPE_W-1:0]  ety_r, ety_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [ADDR_W-1:0]  oh_r, ot_r;
  logic [TYPE_W-1:0]  oty_r;
  logic [COUNT_W-1:0] ocnt_r;
  logic [1:0]         ost_r;

  logic          rd_en, rd_bank;
  logic [AW-1:0] rd_addr;
  logic          wr_en, wr_bank;
  logic [AW-1:0] wr_addr;
  ent_t          wr_data;

  logic          issue;
  ent_t          part;
  logic          part_v;

  assign issue = (cmd.p1_run || cmd.p2_run) && (k_r < used_r);

  always_comb begin
    used_nxt  = used_r;
    bank_nxt  = bank_r;
    k_nxt     = k_r;
    pv_nxt    = pv_r;
    wptr_nxt  = wptr_r;
    spa_nxt   = spa_r;
    sph_nxt   = sph_r;
    spt_nxt   = spt_r;
    last_nxt  = last_r;
    lv_nxt    = lv_r;
    first_nxt = first_r;
    eh_nxt    = eh_r;
    et_nxt    = et_r;
    ety_nxt   = ety_r;
    st_nxt    = st_r;
    rd_en     = 1'b0;
    rd_bank   = bank_r;
    rd_addr   = AW'(k_r);
    wr_en     = 1'b0;
    wr_bank   = ~bank_r;
    wr_addr   = AW'(wptr_r);
    wr_data   = rd_r;
    part      = rd_r;
    part_v    = 1'b0;

    if (cmd.load) begin
      eh_nxt  = '0;
      et_nxt  = '0;
      ety_nxt = '0;
      st_nxt  = ST_BAD;
    end

    if (cmd.pass_init) begin
      k_nxt    = '0;
      pv_nxt   = 1'b0;
      wptr_nxt = '0;
      lv_nxt   = 1'b0;
    end

    if (cmd.p1_run || cmd.p2_run) begin
      if (issue) begin
        rd_en = 1'b1;
        k_nxt = k_r + 1'b1;
      end
      pv_nxt = issue;
    end

    // First pass: the parts of regions that lie below the range.
    if (cmd.p1_run && pv_r) begin
      if (rd_r.tail < h_r) begin
        part_v = 1'b1;
      end else if (rd_r.head < h_r) begin
        part.tail = h_r - 64'd1;
        part_v    = 1'b1;
      end
      if (part_v) begin
        wr_en    = 1'b1;
        wr_data  = part;
        wptr_nxt = wptr_r + 1'b1;
        last_nxt = part;
        lv_nxt   = 1'b1;
      end
    end

    // The span takes over the last lower part when that part touches it with
    // the same type.
    if (cmd.p1_close) begin
      k_nxt     = '0;
      pv_nxt    = 1'b0;
      first_nxt = 1'b1;
      spt_nxt   = t_r;
      if (lv_r && (last_r.ty == ty_r) && (last_r.tail == h_r - 64'd1) &&
          (h_r != '0)) begin
        sph_nxt  = last_r.head;
        spa_nxt  = wptr_r - 1'b1;
        wptr_nxt = wptr_r;
      end else begin
        sph_nxt  = h_r;
        spa_nxt  = wptr_r;
        wptr_nxt = wptr_r + 1'b1;
      end
    end

    // Second pass: upper parts, written after the span slot or merged into it.
    if (cmd.p2_run && pv_r) begin
      if (rd_r.head > t_r) begin
        part_v = 1'b1;
      end else if (rd_r.tail > t_r) begin
        part.head = t_r + 64'd1;
        part_v    = 1'b1;
      end
      if (part_v) begin
        first_nxt = 1'b0;
        if (first_r && (t_r != '1) && (part.ty == ty_r) &&
            (part.head == t_r + 64'd1)) begin
          spt_nxt = part.tail;
        end else begin
          wr_en    = 1'b1;
          wr_data  = part;
          wptr_nxt = wptr_r + 1'b1;
        end
      end
    end

    if (cmd.span_wr) begin
      wr_en   = 1'b1;
      wr_addr = AW'(spa_r);
      wr_data = '{head: sph_r, tail: spt_r, ty: ty_r};
      if (wptr_r > CW'(MAX_REGIONS)) begin
        st_nxt = ST_FULL;
      end else begin
        st_nxt   = ST_OK;
        used_nxt = wptr_r;
        bank_nxt = ~bank_r;
      end
    end

    if (cmd.a_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(used_r - 1'b1);
    end

    if (cmd.a_ev) begin
      if (h_r >= t_r) begin
        st_nxt = ST_BAD;
      end else if ((used_r != '0) && (rd_r.tail >= h_r)) begin
        st_nxt = ST_BAD;
      end else if (used_r >= CW'(MAX_REGIONS)) begin
        st_nxt = ST_FULL;
      end else begin
        wr_en    = 1'b1;
        wr_bank  = bank_r;
        wr_addr  = AW'(used_r);
        wr_data  = '{head: h_r, tail: t_r, ty: ty_r};
        used_nxt = used_r + 1'b1;
        st_nxt   = ST_OK;
      end
    end

    if (cmd.r_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(idx_r);
    end

    if (cmd.r_ev) begin
      if (IW'(idx_r) < IW'(used_r)) begin
        eh_nxt  = rd_r.head;
        et_nxt  = rd_r.tail;
        ety_nxt = rd_r.ty;
        st_nxt  = ST_OK;
      end else begin
        st_nxt = ST_IDX;
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    if (cmd.fin) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bank][wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_bank][rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      bank_r <= 1'b0;
      pv_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      used_r <= used_nxt;
      bank_r <= bank_nxt;
      pv_r   <= pv_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      h_r   <= in_head;
      t_r   <= in_tail;
      ty_r  <= in_type;
      idx_r <= in_index;
    end
    k_r     <= k_nxt;
    wptr_r  <= wptr_nxt;
    spa_r   <= spa_nxt;
    sph_r   <= sph_nxt;
    spt_r   <= spt_nxt;
    last_r  <= last_nxt;
    lv_r    <= lv_nxt;
    first_r <= first_nxt;
    eh_r    <= eh_nxt;
    et_r    <= et_nxt;
    ety_r   <= ety_nxt;
    st_r    <= st_nxt;
    if (cmd.fin) begin
      oh_r   <= eh_r;
      ot_r   <= et_r;
      oty_r  <= ety_r;
      ocnt_r <= COUNT_W'(used_r);
      ost_r  <= st_r;
    end
  end

  assign sts.act      = act_r;
  assign sts.bad      = (h_r > t_r);
  assign sts.pass_end = (k_r == used_r) && !pv_r;
  assign sts.out_free = !ov_r || out_ready;

  assign out_valid  = ov_r;
  assign out_head   = oh_r;
  assign out_tail   = ot_r;
  assign out_type   = oty_r;
  assign out_count  = ocnt_r;
  assign out_status = ost_r;

  `MMRR_ASSERT_IMPL(a_used_limit, 1'b1, used_r <= CW'(MAX_REGIONS))
  `MMRR_ASSERT_IMPL(a_wr_in_depth, wr_en, 32'(wr_addr) < DEPTH)
  `MMRR_ASSERT_NEXT(a_fin_valid, cmd.fin, ov_r)

endmodule

>>> sv/memory_map_range_retype.sv
// ----------------------------------------------------------------------------
// Memory map range retype
// Sorted table of non-overlapping typed memory regions with append, retype
// (split, fill and merge) and read requests.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake     Payload
//   in_if    in   valid/ready   action, range_head, range_tail, region_type,
//                               entry_index
//   out_if   out  valid/ready   entry_head, entry_tail, entry_type,
//                               region_count, status
//
// A retype walks the single read port of the table memory twice, once for the
// parts below the range and once for the parts above it, and builds the new
// table in the other bank.
// Reset is synchronous and empties the table at once; there is no clearing pass.
// A request is taken only when the previous one has finished; a result waits
// in the output register while the next request is already at work.
// ----------------------------------------------------------------------------
module memory_map_range_retype
  import mmrr_pkg::*;
#(
  parameter int MAX_REGIONS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  mmrr_in_if.sink       in_if,
  mmrr_out_if.source    out_if
);

  cmd_t cmd;
  sts_t sts;

  mmrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mmrr_dpath #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (in_if.action),
    .in_head    (in_if.range_head),
    .in_tail    (in_if.range_tail),
    .in_type    (in_if.region_type),
    .in_index   (in_if.entry_index),
    .out_ready  (out_if.ready),
    .out_valid  (out_if.valid),
    .out_head   (out_if.entry_head),
    .out_tail   (out_if.entry_tail),
    .out_type   (out_if.entry_type),
    .out_count  (out_if.region_count),
    .out_status (out_if.status)
  );

endmodule
